FILE: rtl/pnac_pkg.sv
// ----------------------------------------------------------------------------
// pnac_pkg
// shared widths, status codes and defaults of the polygon normal/area unit
// ----------------------------------------------------------------------------
package pnac_pkg;

  localparam int CoordW     = 24;
  localparam int DiffW      = 25;
  localparam int CrossW     = 56;
  localparam int CsumW      = 28;
  localparam int CntW       = 5;
  localparam int NrmW       = 16;
  localparam int AreaW      = 48;
  localparam int MulW       = 29;
  localparam int ProdW      = 58;
  localparam int SubW       = 60;
  localparam int SqW        = 112;
  localparam int RootW      = 56;
  localparam int StatW      = 2;
  localparam int StepW      = 7;
  localparam int MaxVertDef = 4;

  localparam logic [StatW-1:0] STAT_OK    = 2'd0;
  localparam logic [StatW-1:0] STAT_DEGEN = 2'd1;
  localparam logic [StatW-1:0] STAT_FEW   = 2'd2;
  localparam logic [StatW-1:0] STAT_MANY  = 2'd3;

endpackage

FILE: rtl/pnac_alu.sv
// ----------------------------------------------------------------------------
// pnac_alu
// shared signed multiplier with registered product and a wide subtract/compare
// ----------------------------------------------------------------------------
module pnac_alu
  import pnac_pkg::*;
(
  input  logic                    clk_i,
  input  logic signed [MulW-1:0]  mul_a_i,
  input  logic signed [MulW-1:0]  mul_b_i,
  output logic signed [ProdW-1:0] prod_o,
  input  logic        [SubW-1:0]  sub_a_i,
  input  logic        [SubW-1:0]  sub_b_i,
  output logic        [SubW-1:0]  sub_diff_o,
  output logic                    sub_ge_o
);

  logic signed [ProdW-1:0] prod_q;
  logic        [SubW:0]    sub_w;

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a_i * mul_b_i;
  end

  assign prod_o     = prod_q;
  assign sub_w      = {1'b0, sub_a_i} - {1'b0, sub_b_i};
  assign sub_diff_o = sub_w[SubW-1:0];
  assign sub_ge_o   = ~sub_w[SubW];

endmodule

FILE: rtl/polygon_normal_area_centroid_unit.sv
// ----------------------------------------------------------------------------
// polygon_normal_area_centroid_unit
// cross-product fan over a polygon: unit normal, area and centroid
// ----------------------------------------------------------------------------
// A center item is taken without leaving the idle state. A vertex item that
// adds a cross product runs six products through the one shared 29x29
// multiplier. The last vertex of a valid polygon then runs the closing cross
// product, the sum of squares, a one-bit-per-cycle square root, three 28-step
// centroid divisions and, unless the normal is degenerate, three 16-step
// normal divisions on the shared subtractor before its result item is loaded
// into the output register. The unit is not ready while an item is in work.
module polygon_normal_area_centroid_unit
  import pnac_pkg::*;
#(
  parameter int MaxVertices = MaxVertDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [3:0]               paddr,
  input  logic [63:0]              pwdata,
  output logic [63:0]              prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     req_type_i,
  input  logic signed [CoordW-1:0] coord_x_i,
  input  logic signed [CoordW-1:0] coord_y_i,
  input  logic signed [CoordW-1:0] coord_z_i,
  input  logic                     last_vertex_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [NrmW-1:0]   normal_x_o,
  output logic signed [NrmW-1:0]   normal_y_o,
  output logic signed [NrmW-1:0]   normal_z_o,
  output logic [AreaW-1:0]         face_area_o,
  output logic signed [CoordW-1:0] centroid_x_o,
  output logic signed [CoordW-1:0] centroid_y_o,
  output logic signed [CoordW-1:0] centroid_z_o,
  output logic [StatW-1:0]         status_o
);

  localparam int NrmSteps = NrmW;
  localparam int CenSteps = CsumW;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_VTX   = 10'b00_0000_0010,
    S_CROSS = 10'b00_0000_0100,
    S_UPD   = 10'b00_0000_1000,
    S_POST  = 10'b00_0001_0000,
    S_SQR   = 10'b00_0010_0000,
    S_ROOT  = 10'b00_0100_0000,
    S_CHK   = 10'b00_1000_0000,
    S_DIV   = 10'b01_0000_0000,
    S_EMIT  = 10'b10_0000_0000
  } state_e;

  state_e state_q;

  logic [AreaW-1:0]         eps_q;
  logic signed [CoordW-1:0] cur_q    [3];
  logic signed [CoordW-1:0] center_q [3];
  logic signed [CoordW-1:0] first_q  [3];
  logic signed [CoordW-1:0] prev_q   [3];
  logic signed [CrossW-1:0] cs_q     [3];
  logic signed [CsumW-1:0]  csum_q   [3];
  logic [CntW-1:0]          vcnt_q;
  logic                     last_q;
  logic                     closing_q;
  logic [StepW-1:0]         step_q;
  logic [1:0]               comp_q;
  logic [1:0]               part_q;
  logic [1:0]               ptgt_q;
  logic                     pneg_q;
  logic [1:0]               psh_q;
  logic [SqW-1:0]           sq_q;
  logic [SubW-1:0]          rem_q;
  logic [RootW-1:0]         root_q;
  logic [CsumW-1:0]         num_q;
  logic [CsumW-1:0]         quo_q;
  logic                     div_nrm_q;
  logic                     degen_q;
  logic [StatW-1:0]         stat_q;
  logic [AreaW-1:0]         area_q;
  logic signed [NrmW-1:0]   nrm_q    [3];
  logic signed [CoordW-1:0] cen_q    [3];

  logic                     out_valid_q;
  logic signed [NrmW-1:0]   out_nrm_q [3];
  logic [AreaW-1:0]         out_area_q;
  logic signed [CoordW-1:0] out_cen_q [3];
  logic [StatW-1:0]         out_stat_q;

  logic signed [DiffW-1:0]  u [3];
  logic signed [DiffW-1:0]  v [3];
  logic signed [MulW-1:0]   mul_a;
  logic signed [MulW-1:0]   mul_b;
  logic signed [ProdW-1:0]  prod;
  logic [SubW-1:0]          sub_a;
  logic [SubW-1:0]          sub_b;
  logic [SubW-1:0]          sub_diff;
  logic                     sub_ge;
  logic [CrossW-1:0]        mag_sq;
  logic [CrossW-1:0]        mag_div;
  logic [CsumW-1:0]         mag_cen;
  logic [RootW-1:0]         div_den;
  logic [CsumW-1:0]         quo_neg;
  logic                     div_sign;
  logic [StepW-1:0]         div_last;
  logic [SqW-1:0]           sq_add;
  logic                     cfg_wr;
  logic                     in_acc;
  logic                     out_free;

  assign pready     = 1'b1;
  assign cfg_wr     = psel & penable & pwrite & pready & ~paddr[3];
  assign prdata     = paddr[3] ? 64'd0 : {16'd0, eps_q};
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      u[k] = {prev_q[k][CoordW-1], prev_q[k]} - {center_q[k][CoordW-1], center_q[k]};
      v[k] = closing_q ?
             ({first_q[k][CoordW-1], first_q[k]} - {center_q[k][CoordW-1], center_q[k]}) :
             ({cur_q[k][CoordW-1], cur_q[k]} - {center_q[k][CoordW-1], center_q[k]});
    end
  end

  assign mag_sq  = cs_q[comp_q][CrossW-1] ? CrossW'(-cs_q[comp_q]) : cs_q[comp_q];
  assign mag_div = mag_sq;
  assign mag_cen = csum_q[comp_q][CsumW-1] ? CsumW'(-csum_q[comp_q]) : csum_q[comp_q];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == S_CROSS) begin
      case (step_q[2:0])
        3'd0: begin mul_a = MulW'(u[1]); mul_b = MulW'(v[2]); end
        3'd1: begin mul_a = MulW'(u[2]); mul_b = MulW'(v[1]); end
        3'd2: begin mul_a = MulW'(u[2]); mul_b = MulW'(v[0]); end
        3'd3: begin mul_a = MulW'(u[0]); mul_b = MulW'(v[2]); end
        3'd4: begin mul_a = MulW'(u[0]); mul_b = MulW'(v[1]); end
        3'd5: begin mul_a = MulW'(u[1]); mul_b = MulW'(v[0]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state_q == S_SQR) begin
      case (part_q)
        2'd0: begin
          mul_a = {1'b0, mag_sq[27:0]};
          mul_b = {1'b0, mag_sq[27:0]};
        end
        2'd1: begin
          mul_a = {1'b0, mag_sq[55:28]};
          mul_b = {1'b0, mag_sq[27:0]};
        end
        default: begin
          mul_a = {1'b0, mag_sq[55:28]};
          mul_b = {1'b0, mag_sq[55:28]};
        end
      endcase
    end
  end

  // square root trial subtract or restoring division step
  assign div_den = div_nrm_q ? root_q : RootW'(vcnt_q);
  always_comb begin
    if (state_q == S_ROOT) begin
      sub_a = {rem_q[SubW-3:0], sq_q[SqW-1:SqW-2]};
      sub_b = {2'b00, root_q, 2'b01};
    end else begin
      sub_a = {rem_q[SubW-2:0], num_q[CsumW-1]};
      sub_b = {4'd0, div_den};
    end
  end

  always_comb begin
    case (psh_q)
      2'd0:    sq_add = SqW'(prod[CrossW-1:0]);
      2'd1:    sq_add = SqW'(prod[CrossW-1:0]) << 29;
      default: sq_add = SqW'(prod[CrossW-1:0]) << 56;
    endcase
  end

  assign div_sign = div_nrm_q ? cs_q[comp_q][CrossW-1] : csum_q[comp_q][CsumW-1];
  assign quo_neg  = div_sign ? (~quo_q + 1'b1) : quo_q;
  assign div_last = div_nrm_q ? StepW'(NrmSteps + 1) : StepW'(CenSteps + 1);

  pnac_alu u_alu (
    .clk_i      (clk_i),
    .mul_a_i    (mul_a),
    .mul_b_i    (mul_b),
    .prod_o     (prod),
    .sub_a_i    (sub_a),
    .sub_b_i    (sub_b),
    .sub_diff_o (sub_diff),
    .sub_ge_o   (sub_ge)
  );

  // control and polygon state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      eps_q       <= AreaW'(1);
      vcnt_q      <= '0;
      out_valid_q <= 1'b0;
      closing_q   <= 1'b0;
      step_q      <= '0;
      comp_q      <= '0;
      part_q      <= '0;
      div_nrm_q   <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        center_q[k] <= '0;
        first_q[k]  <= '0;
        prev_q[k]   <= '0;
        cs_q[k]     <= '0;
        csum_q[k]   <= '0;
      end
    end else begin
      if (cfg_wr) begin
        eps_q <= pwdata[AreaW-1:0];
      end
      if (out_valid_q && out_ready_i && state_q != S_EMIT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            cur_q[0] <= coord_x_i;
            cur_q[1] <= coord_y_i;
            cur_q[2] <= coord_z_i;
            last_q   <= last_vertex_i;
            if (!req_type_i) begin
              center_q[0] <= coord_x_i;
              center_q[1] <= coord_y_i;
              center_q[2] <= coord_z_i;
              vcnt_q      <= '0;
              for (int k = 0; k < 3; k++) begin
                cs_q[k]   <= '0;
                csum_q[k] <= '0;
              end
            end else begin
              state_q <= S_VTX;
            end
          end
        end
        S_VTX: begin
          if (vcnt_q != '1) begin
            vcnt_q <= vcnt_q + 1'b1;
          end
          closing_q <= 1'b0;
          step_q    <= '0;
          if (vcnt_q < CntW'(MaxVertices)) begin
            if (vcnt_q == '0) begin
              first_q <= cur_q;
              state_q <= S_UPD;
            end else begin
              state_q <= S_CROSS;
            end
          end else begin
            state_q <= S_POST;
          end
        end
        S_CROSS: begin
          if (step_q != '0) begin
            cs_q[ptgt_q] <= pneg_q ? (cs_q[ptgt_q] - prod[CrossW-1:0]) :
                                     (cs_q[ptgt_q] + prod[CrossW-1:0]);
          end
          if (step_q == StepW'(6)) begin
            step_q  <= '0;
            comp_q  <= '0;
            part_q  <= '0;
            state_q <= closing_q ? S_SQR : S_UPD;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        S_UPD: begin
          for (int k = 0; k < 3; k++) begin
            prev_q[k] <= cur_q[k];
            csum_q[k] <= csum_q[k] + CsumW'(cur_q[k]);
          end
          state_q <= S_POST;
        end
        S_POST: begin
          if (!last_q) begin
            state_q <= S_IDLE;
          end else if (vcnt_q < CntW'(3)) begin
            stat_q  <= STAT_FEW;
            state_q <= S_EMIT;
          end else if (vcnt_q > CntW'(MaxVertices)) begin
            stat_q  <= STAT_MANY;
            state_q <= S_EMIT;
          end else begin
            closing_q <= 1'b1;
            step_q    <= '0;
            sq_q      <= '0;
            state_q   <= S_CROSS;
          end
        end
        S_SQR: begin
          if (step_q != '0) begin
            sq_q <= sq_q + sq_add;
          end
          if (part_q == 2'd2) begin
            part_q <= '0;
            comp_q <= comp_q + 1'b1;
          end else begin
            part_q <= part_q + 1'b1;
          end
          if (step_q == StepW'(9)) begin
            step_q  <= '0;
            rem_q   <= '0;
            root_q  <= '0;
            state_q <= S_ROOT;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        S_ROOT: begin
          step_q <= step_q + 1'b1;
          rem_q  <= sub_ge ? sub_diff : sub_a;
          root_q <= {root_q[RootW-2:0], sub_ge};
          sq_q   <= sq_q << 2;
          if (step_q == StepW'(RootW - 1)) begin
            state_q <= S_CHK;
          end
        end
        S_CHK: begin
          area_q    <= (|root_q[RootW-1:AreaW+1]) ? '1 : root_q[AreaW:1];
          degen_q   <= (root_q <= RootW'(eps_q));
          stat_q    <= (root_q <= RootW'(eps_q)) ? STAT_DEGEN : STAT_OK;
          for (int k = 0; k < 3; k++) begin
            nrm_q[k] <= '0;
          end
          step_q    <= '0;
          comp_q    <= '0;
          div_nrm_q <= 1'b0;
          state_q   <= S_DIV;
        end
        S_DIV: begin
          if (step_q == '0) begin
            step_q <= step_q + 1'b1;
            quo_q  <= '0;
            if (div_nrm_q) begin
              rem_q <= SubW'(mag_div[CrossW-1:2]);
              num_q <= {mag_div[1:0], 26'd0};
            end else begin
              rem_q <= '0;
              num_q <= mag_cen;
            end
          end else if (step_q != div_last) begin
            step_q <= step_q + 1'b1;
            rem_q  <= sub_ge ? sub_diff : sub_a;
            quo_q  <= {quo_q[CsumW-2:0], sub_ge};
            num_q  <= num_q << 1;
          end else begin
            step_q <= '0;
            if (div_nrm_q) begin
              nrm_q[comp_q] <= quo_neg[NrmW-1:0];
            end else begin
              cen_q[comp_q] <= quo_neg[CoordW-1:0];
            end
            if (comp_q == 2'd2) begin
              comp_q <= '0;
              if (!div_nrm_q && !degen_q) begin
                div_nrm_q <= 1'b1;
              end else begin
                state_q <= S_EMIT;
              end
            end else begin
              comp_q <= comp_q + 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_stat_q  <= stat_q;
            if (stat_q == STAT_FEW || stat_q == STAT_MANY) begin
              out_area_q <= '0;
              for (int k = 0; k < 3; k++) begin
                out_nrm_q[k] <= '0;
                out_cen_q[k] <= '0;
              end
            end else begin
              out_area_q <= area_q;
              out_nrm_q  <= nrm_q;
              out_cen_q  <= cen_q;
            end
            vcnt_q <= '0;
            for (int k = 0; k < 3; k++) begin
              cs_q[k]   <= '0;
              csum_q[k] <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // metadata of the product in flight
  always_ff @(posedge clk_i) begin
    if (state_q == S_CROSS) begin
      ptgt_q <= step_q[2:1];
      pneg_q <= step_q[0];
    end
    psh_q <= part_q;
  end

  assign out_valid_o  = out_valid_q;
  assign normal_x_o   = out_nrm_q[0];
  assign normal_y_o   = out_nrm_q[1];
  assign normal_z_o   = out_nrm_q[2];
  assign face_area_o  = out_area_q;
  assign centroid_x_o = out_cen_q[0];
  assign centroid_y_o = out_cen_q[1];
  assign centroid_z_o = out_cen_q[2];
  assign status_o     = out_stat_q;

endmodule

FILE: rtl/pnac_checker.sv
// ----------------------------------------------------------------------------
// pnac_checker
// port-level checks of the polygon normal/area unit, bound to the top level
// ----------------------------------------------------------------------------
module pnac_checker
  import pnac_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic signed [NrmW-1:0]   normal_x_o,
  input logic signed [NrmW-1:0]   normal_y_o,
  input logic signed [NrmW-1:0]   normal_z_o,
  input logic [AreaW-1:0]         face_area_o,
  input logic signed [CoordW-1:0] centroid_x_o,
  input logic signed [CoordW-1:0] centroid_y_o,
  input logic signed [CoordW-1:0] centroid_z_o,
  input logic [StatW-1:0]         status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result item dropped or changed while stalled");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_DEGEN |->
      normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0)
    else $error("degenerate normal not zero");

  a_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_FEW || status_o == STAT_MANY) |->
      face_area_o == '0 && centroid_x_o == '0 && centroid_y_o == '0 &&
      centroid_z_o == '0 && normal_x_o == '0 && normal_y_o == '0)
    else $error("bad vertex count with nonzero fields");

  a_ok_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_OK |->
      normal_x_o != '0 || normal_y_o != '0 || normal_z_o != '0)
    else $error("valid normal is zero");

endmodule

bind polygon_normal_area_centroid_unit pnac_checker u_pnac_checker (.*);

FILE: verif/polygon_normal_area_centroid_unit_tb.sv
// ----------------------------------------------------------------------------
// polygon_normal_area_centroid_unit_tb
// Drives center points and polygon vertices into the unit, with the degenerate
// threshold set to several values through the register port. A local model
// of the cross-product fan predicts normal, area, centroid and status for
// each closed polygon; every result item is compared field by field.
// ----------------------------------------------------------------------------
module polygon_normal_area_centroid_unit_tb;
  import pnac_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxV = MaxVertDef;
  localparam logic [47:0] EpsMax = 48'hFFFF_FFFF_FFFF;
  localparam logic ReqCenter = 1'b0;
  localparam logic ReqVertex = 1'b1;
  localparam logic [3:0] AddrEpsilon = 4'd0;

  typedef struct packed {
    logic signed [NrmW-1:0]   nx;
    logic signed [NrmW-1:0]   ny;
    logic signed [NrmW-1:0]   nz;
    logic [AreaW-1:0]         area;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [CoordW-1:0] cz;
    logic [StatW-1:0]         status;
  } face_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic req_type_i = 1'b0;
  logic signed [CoordW-1:0] coord_x_i = '0, coord_y_i = '0, coord_z_i = '0;
  logic last_vertex_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [NrmW-1:0] normal_x_o, normal_y_o, normal_z_o;
  logic [AreaW-1:0] face_area_o;
  logic signed [CoordW-1:0] centroid_x_o, centroid_y_o, centroid_z_o;
  logic [StatW-1:0] status_o;

  polygon_normal_area_centroid_unit dut (.*);

  always #4 clk_i = ~clk_i;

  // model state
  logic [47:0] eps_q;
  longint center_pt[3], first_pt[3], prev_pt[3], coord_acc[3];
  logic signed [CrossW-1:0] cross_acc[3];
  int vert_cnt;
  face_result_t face_expect_q[$];

  int mismatches = 0;
  int hold_cycles = 0;
  int burst_left = 0;

  function automatic logic [63:0] int_sqrt(logic [127:0] n);
    logic [63:0] r, cand;
    r = '0;
    for (int b = 57; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      if ({64'd0, cand} * {64'd0, cand} <= n) r = cand;
    end
    return r;
  endfunction

  task automatic clear_face();
    for (int i = 0; i < 3; i++) begin
      first_pt[i] = 0; prev_pt[i] = 0; coord_acc[i] = 0; cross_acc[i] = '0;
    end
    vert_cnt = 0;
  endtask

  task automatic add_cross(longint a[3], longint b[3]);
    longint u[3], v[3], c[3];
    for (int i = 0; i < 3; i++) begin
      u[i] = a[i] - center_pt[i];
      v[i] = b[i] - center_pt[i];
    end
    c[0] = u[1] * v[2] - u[2] * v[1];
    c[1] = u[2] * v[0] - u[0] * v[2];
    c[2] = u[0] * v[1] - u[1] * v[0];
    for (int i = 0; i < 3; i++) cross_acc[i] = cross_acc[i] + c[i][CrossW-1:0];
  endtask

  task automatic predict_face(logic rt, longint p[3], logic last);
    face_result_t r;
    logic [127:0] sq, m, q;
    logic [63:0] len;
    if (rt == ReqCenter) begin
      center_pt = p;
      clear_face();
      return;
    end
    if (vert_cnt < MaxV) begin
      if (vert_cnt == 0) first_pt = p;
      else add_cross(prev_pt, p);
      prev_pt = p;
      for (int i = 0; i < 3; i++) coord_acc[i] += p[i];
    end
    if (vert_cnt < 31) vert_cnt++;
    if (!last) return;
    r = '0;
    if (vert_cnt < 3) r.status = STAT_FEW;
    else if (vert_cnt > MaxV) r.status = STAT_MANY;
    else begin
      add_cross(prev_pt, first_pt);
      sq = '0;
      for (int i = 0; i < 3; i++) begin
        m = cross_acc[i] < 0 ? 128'(-cross_acc[i]) : 128'(cross_acc[i]);
        sq += m * m;
      end
      len = int_sqrt(sq);
      r.area = (len >> 1) > 64'(EpsMax) ? EpsMax : AreaW'(len >> 1);
      r.cx = CoordW'(coord_acc[0] / vert_cnt);
      r.cy = CoordW'(coord_acc[1] / vert_cnt);
      r.cz = CoordW'(coord_acc[2] / vert_cnt);
      if (len <= 64'(eps_q)) r.status = STAT_DEGEN;
      else begin
        for (int i = 0; i < 3; i++) begin
          m = cross_acc[i] < 0 ? 128'(-cross_acc[i]) : 128'(cross_acc[i]);
          q = (m << 14) / 128'(len);
          if (cross_acc[i] < 0) q = -q;
          if (i == 0) r.nx = q[15:0];
          else if (i == 1) r.ny = q[15:0];
          else r.nz = q[15:0];
        end
        r.status = STAT_OK;
      end
    end
    clear_face();
    face_expect_q.push_back(r);
  endtask

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
    mismatches++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    face_result_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (face_expect_q.size() == 0) report_mismatch("unexpected item", 64'd0, 64'd0);
      else begin
        w = face_expect_q.pop_front();
        if (normal_x_o !== w.nx)
          report_mismatch("normal_x", 64'(normal_x_o), 64'(w.nx));
        if (normal_y_o !== w.ny)
          report_mismatch("normal_y", 64'(normal_y_o), 64'(w.ny));
        if (normal_z_o !== w.nz)
          report_mismatch("normal_z", 64'(normal_z_o), 64'(w.nz));
        if (face_area_o !== w.area)
          report_mismatch("face_area", 64'(face_area_o), 64'(w.area));
        if (centroid_x_o !== w.cx)
          report_mismatch("centroid_x", 64'(centroid_x_o), 64'(w.cx));
        if (centroid_y_o !== w.cy)
          report_mismatch("centroid_y", 64'(centroid_y_o), 64'(w.cy));
        if (centroid_z_o !== w.cz)
          report_mismatch("centroid_z", 64'(centroid_z_o), 64'(w.cz));
        if (status_o !== w.status)
          report_mismatch("status", 64'(status_o), 64'(w.status));
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk_i) begin
    int mode, left;
    if (hold_cycles > 0) begin
      out_ready_i = 1'b0;
      hold_cycles--;
    end else begin
      if (left <= 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 96);
      end
      left--;
      case (mode)
        0: out_ready_i = 1'b1;
        1: out_ready_i = ($urandom_range(0, 1) == 0);
        2: out_ready_i = ($urandom_range(0, 3) == 0);
        default: out_ready_i = ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  task automatic send_item(logic rt, longint x, longint y, longint z, logic last);
    longint p[3];
    if (burst_left <= 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                              : $urandom_range(1, 10);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    req_type_i = rt;
    coord_x_i = x[CoordW-1:0];
    coord_y_i = y[CoordW-1:0];
    coord_z_i = z[CoordW-1:0];
    last_vertex_i = last;
    do @(posedge clk_i); while (!in_ready_o);
    p[0] = longint'(coord_x_i);
    p[1] = longint'(coord_y_i);
    p[2] = longint'(coord_z_i);
    predict_face(rt, p, last);
  endtask

  task automatic drain_all();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    burst_left = 0;
    while (face_expect_q.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  task automatic write_epsilon(logic [47:0] v);
    drain_all();
    psel = 1'b1; pwrite = 1'b1; paddr = AddrEpsilon; pwdata = {16'd0, v};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    eps_q = v;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  function automatic longint rand_coord();
    case ($urandom_range(0, 3))
      0: return longint'($urandom_range(0, 16777215)) - 8388608;
      1: return longint'($urandom_range(0, 65535)) - 32768;
      2: return $urandom_range(0, 1) ? 8388607 : -8388608;
      default: return longint'($urandom_range(0, 1023)) - 512;
    endcase
  endfunction

  task automatic send_polygon(int n, bit early_center);
    send_item(ReqCenter, rand_coord(), rand_coord(), rand_coord(),
              1'($urandom_range(0, 1)));
    for (int i = 0; i < n; i++) begin
      if (early_center && i == n / 2) begin
        send_item(ReqCenter, rand_coord(), rand_coord(), rand_coord(), 1'b0);
      end
      send_item(ReqVertex, rand_coord(), rand_coord(), rand_coord(), i == n - 1);
    end
  endtask

  task automatic test_directed();
    // vertex without center, uses the center left from before (the reset center on the first call)
    send_item(ReqVertex, 4096, 0, 0, 0);
    send_item(ReqVertex, 0, 4096, 0, 0);
    send_item(ReqVertex, 0, 0, 4096, 1);
    // extremes
    send_item(ReqCenter, -8388608, -8388608, -8388608, 1);
    send_item(ReqVertex, 8388607, -8388608, 8388607, 0);
    send_item(ReqVertex, -8388608, 8388607, 8388607, 0);
    send_item(ReqVertex, 8388607, 8388607, -8388608, 0);
    send_item(ReqVertex, 8388607, 8388607, 8388607, 1);
    // too few
    send_item(ReqVertex, 100, 200, 300, 1);
    send_item(ReqVertex, 100, 200, 300, 0);
    send_item(ReqVertex, -7, 9, 1, 1);
    // too many
    for (int i = 0; i < MaxV + 2; i++) send_item(ReqVertex, i * 999, -i * 77, 5, i == MaxV + 1);
    // collinear, degenerate
    send_item(ReqCenter, 0, 0, 0, 0);
    send_item(ReqVertex, 1, 1, 1, 0);
    send_item(ReqVertex, 2, 2, 2, 0);
    send_item(ReqVertex, -3, -3, -3, 1);
    // center mid-polygon
    send_item(ReqVertex, 50, 0, 0, 0);
    send_item(ReqCenter, 10, 10, 10, 0);
    send_item(ReqVertex, -4096, 0, 0, 0);
    send_item(ReqVertex, 0, -4096, 0, 0);
    send_item(ReqVertex, 0, 0, -4096, 1);
  endtask

  task automatic test_random(int budget);
    int sent;
    sent = 0;
    while (sent < budget) begin
      int n;
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, MaxV + 3) : $urandom_range(3, MaxV);
      send_polygon(n, $urandom_range(0, 9) == 0);
      sent += n + 1;
    end
  endtask

  task automatic test_backpressure();
    drain_all();
    hold_cycles = 3000;
    repeat (8) send_polygon(3, 0);
  endtask

  initial begin
    eps_q = 48'd1;
    clear_face();
    for (int i = 0; i < 3; i++) center_pt[i] = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    write_epsilon(48'd0);
    test_directed();
    write_epsilon(EpsMax);
    test_random(60);
    write_epsilon(48'd1);
    test_random(600);
    test_backpressure();
    write_epsilon({24'd0, 24'h1000});
    test_random(500);
    write_epsilon(48'({$urandom_range(0, 255), $urandom()} >> $urandom_range(0, 40)));
    test_random(500);
    drain_all();
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #50ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
